[hw/rtl/three_band_spectral_eq_gain_macros.svh]
// Assertion macros shared by the equalizer gain RTL.
// Needs a clock named clk and a reset named rst in the module that uses it.
`ifndef THREE_BAND_SPECTRAL_EQ_GAIN_MACROS_SVH
`define THREE_BAND_SPECTRAL_EQ_GAIN_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define TBEQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define TBEQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hw/rtl/tbeq_pkg.sv]
// Package for the three-band spectral equalizer gain block.
// Field widths, fixed-point constants, register indexes and shared types; no dependencies.
package tbeq_pkg;

  // Spectrum size; bins at or above this index are never scaled
  localparam int unsigned BIN_COUNT = 1024;

  // Field widths
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned FREQ_W     = 20;
  localparam int unsigned MAG_W      = 24;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned IN_TDATA_W = 56;
  localparam int unsigned WEIGHT_W   = 17;
  localparam int unsigned BAND_W     = 32;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_LOW_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MID_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_BIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_BIN  = 3'd4;

  localparam logic [GAIN_W-1:0] GAIN_UNITY    = 16'd4096;
  localparam logic [IDX_W-1:0]  FIRST_BIN_RST = 10'd0;
  localparam logic [IDX_W-1:0]  LAST_BIN_RST  = 10'd1023;

  // Band edges in 1/16 Hz: 200 Hz, 250 Hz, 1900 Hz, 2000 Hz
  localparam logic [FREQ_W-1:0] LOW_KNEE  = 20'd3200;
  localparam logic [FREQ_W-1:0] LOW_END   = 20'd4000;
  localparam logic [FREQ_W-1:0] HIGH_KNEE = 20'd30400;
  localparam logic [FREQ_W-1:0] HIGH_END  = 20'd32000;

  // Q0.16 unity weight
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;

  // Both slopes reduce to floor(x / 25) with x below 2^21:
  // 65536/800 = 2048/25 and 65536/1600 = 1024/25.
  // ceil(2^26 / 25) is exact for x * 11 < 2^26.
  localparam int unsigned DIV_X_W   = 21;
  localparam int unsigned RECIP_W   = 22;
  localparam int unsigned DIV_P_W   = DIV_X_W + RECIP_W;
  localparam int unsigned RECIP_SH  = 26;
  localparam logic [RECIP_W-1:0] RECIP_25 = 22'd2684355;

  // Largest combined Q4.28 gain: unity weight times the largest band gain
  localparam logic [BAND_W-1:0] GAIN_MAX = 32'hFFFF_0000;

  localparam logic [MAG_W-1:0] MAG_MAX = 24'hFF_FFFF;

  // Band weights of one bin, Q0.16 with 17 bits so unity fits
  typedef struct packed {
    logic [WEIGHT_W-1:0] low;
    logic [WEIGHT_W-1:0] mid;
    logic [WEIGHT_W-1:0] high;
  } weights_t;

endpackage

[hw/rtl/tbeq_weight.sv]
// Band weight pipeline: bin frequency in, registered low/mid/high Q0.16 weights out.
// Depends on tbeq_pkg.
module tbeq_weight (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic [tbeq_pkg::FREQ_W-1:0]   freq,
  output tbeq_pkg::weights_t            weights
);
  import tbeq_pkg::*;

  logic [FREQ_W-1:0]  lo_diff;
  logic [FREQ_W-1:0]  hi_diff;
  logic               lo_full;
  logic               lo_slope;
  logic               hi_full;
  logic               hi_slope;
  logic [DIV_X_W-1:0] x_lo;
  logic [DIV_X_W-1:0] x_hi;
  logic [DIV_P_W-1:0] prod_lo;
  logic [DIV_P_W-1:0] prod_hi;
  logic [15:0]        q_lo;
  logic [15:0]        q_hi;
  logic               lo_full_d;
  logic               lo_slope_d;
  logic               hi_full_d;
  logic               hi_slope_d;
  logic [WEIGHT_W-1:0] wl;
  logic [WEIGHT_W-1:0] wh;
  logic [WEIGHT_W:0]   wl_wh;
  logic [WEIGHT_W-1:0] wm;
  weights_t            weights_q;

  // Classify the frequency and scale the slope distance by 2048 or 1024
  assign lo_diff = LOW_END - freq;
  assign hi_diff = freq - HIGH_KNEE;

  always_ff @(posedge clk) begin
    if (rst) begin
      lo_full  <= 1'b0;
      lo_slope <= 1'b0;
      hi_full  <= 1'b0;
      hi_slope <= 1'b0;
    end else if (en) begin
      lo_full  <= (freq <= LOW_KNEE);
      lo_slope <= (freq > LOW_KNEE) && (freq < LOW_END);
      hi_full  <= (freq >= HIGH_END);
      hi_slope <= (freq > HIGH_KNEE) && (freq < HIGH_END);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_lo <= {lo_diff[9:0], 11'b0};
      x_hi <= {hi_diff[10:0], 10'b0};
    end
  end

  // Divide by 25 through the reciprocal
  assign prod_lo = DIV_P_W'(x_lo) * DIV_P_W'(RECIP_25);
  assign prod_hi = DIV_P_W'(x_hi) * DIV_P_W'(RECIP_25);

  always_ff @(posedge clk) begin
    if (en) begin
      q_lo       <= prod_lo[RECIP_SH+15:RECIP_SH];
      q_hi       <= prod_hi[RECIP_SH+15:RECIP_SH];
      lo_full_d  <= lo_full;
      lo_slope_d <= lo_slope;
      hi_full_d  <= hi_full;
      hi_slope_d <= hi_slope;
    end
  end

  // Select the weights and give the mid band the remainder
  always_comb begin
    if (lo_full_d) begin
      wl = WEIGHT_ONE;
    end else if (lo_slope_d) begin
      wl = {1'b0, q_lo};
    end else begin
      wl = '0;
    end
    if (hi_full_d) begin
      wh = WEIGHT_ONE;
    end else if (hi_slope_d) begin
      wh = {1'b0, q_hi};
    end else begin
      wh = '0;
    end
    wl_wh = {1'b0, wl} + {1'b0, wh};
    if (wl_wh < {1'b0, WEIGHT_ONE}) begin
      wm = WEIGHT_ONE - wl_wh[WEIGHT_W-1:0];
    end else begin
      wm = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      weights_q.low  <= wl;
      weights_q.mid  <= wm;
      weights_q.high <= wh;
    end
  end

  assign weights = weights_q;

endmodule

[hw/rtl/three_band_spectral_eq_gain.sv]
// Three-band spectral equalizer gain: bin magnitude times a frequency-weighted band gain.
// Depends on tbeq_pkg, tbeq_weight and three_band_spectral_eq_gain_macros.svh.
//
// One bin is accepted every cycle while the skid register is empty, and results leave in order.
// The multiplier chain runs through weight classification, divide by the
// slope through a reciprocal multiply, weight selection, three band products, their
// sum, the magnitude product, and the saturating output register. A two-entry output
// stage (output register plus skid register) takes a result while the consumer stalls;
// s_axis_tready depends only on registered state. Bins whose index lies from first_bin
// to last_bin (and below the bin count) are scaled; all others pass unchanged.
// Write configuration only while no transaction is in flight.
module three_band_spectral_eq_gain (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [tbeq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tbeq_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // bin_index [9:0], bin_frequency [29:10], magnitude_in [53:30], zero [55:54]
  input  logic [tbeq_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // magnitude_out [23:0]
  output logic [tbeq_pkg::MAG_W-1:0]        m_axis_tdata
);
  import tbeq_pkg::*;
  `include "three_band_spectral_eq_gain_macros.svh"

  localparam int unsigned DEPTH = 6;
  localparam int unsigned PROD_W = MAG_W + BAND_W;

  logic [GAIN_W-1:0] low_band_gain;
  logic [GAIN_W-1:0] mid_band_gain;
  logic [GAIN_W-1:0] high_band_gain;
  logic [IDX_W-1:0]  first_bin;
  logic [IDX_W-1:0]  last_bin;

  logic [IDX_W-1:0]  bin_index;
  logic [FREQ_W-1:0] bin_frequency;
  logic [MAG_W-1:0]  magnitude_in;
  logic              in_range;

  logic              en;
  logic [DEPTH-1:0]  v;
  logic              scale_q [DEPTH];
  logic [MAG_W-1:0]  mag_q   [DEPTH];

  weights_t          weights;
  logic [WEIGHT_W:0] weight_total;
  logic [BAND_W:0]   p_low;
  logic [BAND_W:0]   p_mid;
  logic [BAND_W:0]   p_high;
  logic [BAND_W+1:0] gain_sum;
  logic [BAND_W-1:0] gain_q;
  logic [PROD_W-1:0] mag_prod;
  logic [MAG_W-1:0]  result;

  logic              out_valid;
  logic [MAG_W-1:0]  out_data;
  logic              skid_valid;
  logic [MAG_W-1:0]  skid_data;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      low_band_gain  <= GAIN_UNITY;
      mid_band_gain  <= GAIN_UNITY;
      high_band_gain <= GAIN_UNITY;
      first_bin      <= FIRST_BIN_RST;
      last_bin       <= LAST_BIN_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_LOW_GAIN:  low_band_gain  <= cfg_wr_data;
        REG_MID_GAIN:  mid_band_gain  <= cfg_wr_data;
        REG_HIGH_GAIN: high_band_gain <= cfg_wr_data;
        REG_FIRST_BIN: first_bin      <= cfg_wr_data[IDX_W-1:0];
        REG_LAST_BIN:  last_bin       <= cfg_wr_data[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpack the input transaction and test the bin range
  assign bin_index     = s_axis_tdata[IDX_W-1:0];
  assign bin_frequency = s_axis_tdata[IDX_W+FREQ_W-1:IDX_W];
  assign magnitude_in  = s_axis_tdata[IDX_W+FREQ_W+MAG_W-1:IDX_W+FREQ_W];
  assign in_range      = (bin_index >= first_bin) && (bin_index <= last_bin) &&
                         (17'(bin_index) < 17'(BIN_COUNT));

  // Whole pipeline advances unless the skid register is occupied
  assign en            = !skid_valid;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[DEPTH-2:0], s_axis_tvalid};
    end
  end

  // Carry the bypass magnitude and the scale flag alongside the arithmetic
  always_ff @(posedge clk) begin
    if (en) begin
      scale_q[0] <= in_range;
      mag_q[0]   <= magnitude_in;
      for (int i = 1; i < DEPTH; i++) begin
        scale_q[i] <= scale_q[i-1];
        mag_q[i]   <= mag_q[i-1];
      end
    end
  end

  // Stages one to three: band weights
  tbeq_weight u_weight (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .freq    (bin_frequency),
    .weights (weights)
  );

  // Stage four: weight times band gain
  always_ff @(posedge clk) begin
    if (en) begin
      p_low  <= (BAND_W+1)'(weights.low)  * (BAND_W+1)'(low_band_gain);
      p_mid  <= (BAND_W+1)'(weights.mid)  * (BAND_W+1)'(mid_band_gain);
      p_high <= (BAND_W+1)'(weights.high) * (BAND_W+1)'(high_band_gain);
    end
  end

  // Stage five: combined Q4.28 gain; weights sum to unity so it fits 32 bits
  assign gain_sum = {1'b0, p_low} + {1'b0, p_mid} + {1'b0, p_high};

  always_ff @(posedge clk) begin
    if (en) begin
      gain_q <= gain_sum[BAND_W-1:0];
    end
  end

  // Stage six: magnitude times gain
  always_ff @(posedge clk) begin
    if (en) begin
      mag_prod <= PROD_W'(mag_q[4]) * PROD_W'(gain_q);
    end
  end

  // Drop the fraction, saturate, or bypass
  always_comb begin
    if (!scale_q[5]) begin
      result = mag_q[5];
    end else if (|mag_prod[PROD_W-1:MAG_W+28]) begin
      result = MAG_MAX;
    end else begin
      result = mag_prod[MAG_W+27:28];
    end
  end

  // Output register with skid: park a result while the consumer stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_axis_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= v[DEPTH-1];
      end
    end else if (v[DEPTH-1] && en) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_axis_tready) begin
      out_data <= skid_valid ? skid_data : result;
    end else if (v[DEPTH-1] && en) begin
      skid_data <= result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // Sum of the three band weights of the bin in stage three
  assign weight_total = (WEIGHT_W+1)'(weights.low) + (WEIGHT_W+1)'(weights.mid) +
                        (WEIGHT_W+1)'(weights.high);

  // Assertions
  `TBEQ_ASSERT(a_skid_needs_out, !skid_valid || out_valid, "skid full with empty output")
  `TBEQ_ASSERT(a_accept_enters, (s_axis_tvalid && s_axis_tready) |=> v[0], "accepted bin lost")
  `TBEQ_ASSERT(a_weight_sum, v[2] |-> (weight_total == (WEIGHT_W+1)'(WEIGHT_ONE)), "bad weights")
  `TBEQ_ASSERT(a_gain_bound, v[4] |-> (gain_q <= GAIN_MAX), "combined gain out of range")

endmodule
